// ===== sv/ucal_pkg.sv =====
// ----------------------------------------------------------------------------
// ucal_pkg
// Shared types and constants for the Unix time to calendar converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucal_pkg;

    // Pipeline depth of each section
    localparam int DAY_STAGES   = 3;
    localparam int FIELD_STAGES = 7;
    localparam int TOTAL_STAGES = DAY_STAGES + FIELD_STAGES;

    // Seconds to days: (s >> 7) / 675, reciprocal floor(2^35 / 675)
    localparam int DAY_DIV   = 675;
    localparam int DAY_RECIP = 50903316;

    // x / 15 for x below 2^15, reciprocal floor(2^19 / 15)
    localparam int MIN_RECIP = 34952;
    localparam int SIXTY     = 60;

    // Days from 1600-03-01 to 1970-01-01
    localparam int EPOCH_SHIFT = 135080;
    localparam int DAYS_400Y   = 146097;
    localparam int DAYS_100Y   = 36524;
    localparam int DAYS_4Y     = 1461;
    localparam int DAYS_1Y     = 365;
    localparam int BASE_YEAR   = 1600;

    // x / 1461 for x below 2^16, reciprocal floor(2^26 / 1461)
    localparam int QUAD_RECIP = 45933;

    // Month index (0 is March) where January starts
    localparam logic [3:0] JAN_IDX = 4'd10;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } ymd_t;

    // First day of each month within a March-first year
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] res;
        unique case (idx)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/ucal_in_if.sv =====
// ----------------------------------------------------------------------------
// ucal_in_if
// Timestamp channel: valid/ready with a 32-bit Unix seconds payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ucal_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

// ===== sv/ucal_out_if.sv =====
// ----------------------------------------------------------------------------
// ucal_out_if
// Calendar channel: valid/ready with date and time of day.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ucal_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface

// ===== sv/ucal_day_split.sv =====
// ----------------------------------------------------------------------------
// ucal_day_split
// Three-stage split of Unix seconds into whole days and seconds of day.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucal_day_split (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] unix_seconds,
    output logic [15:0] days,
    output logic [16:0] sod
);

    // stage 1: reciprocal product of seconds / 128
    logic [24:0] x1_reg;
    logic [6:0]  lo1_reg;
    logic [50:0] prod_reg;
    logic [50:0] prod_next;

    // stage 2: quotient estimate and its back product
    logic [24:0] x2_reg;
    logic [6:0]  lo2_reg;
    logic [15:0] q2_reg;
    logic [25:0] qm2_reg;
    logic [25:0] qm2_next;

    // stage 3: correction
    logic [10:0] rem;
    logic [10:0] rem_fix;
    logic [15:0] days_next;
    logic [15:0] days_reg;
    logic [16:0] sod_reg;
    logic [16:0] sod_next;

    always_comb
    begin
        prod_next = 51'(unix_seconds[31:7]) * 51'(ucal_pkg::DAY_RECIP);
        qm2_next  = 26'(prod_reg[50:35]) * 26'(ucal_pkg::DAY_DIV);
    end

    always_comb
    begin
        rem = 11'(x2_reg - qm2_reg[24:0]);
        if (rem >= 11'(ucal_pkg::DAY_DIV))
        begin
            days_next = q2_reg + 16'd1;
            rem_fix   = rem - 11'(ucal_pkg::DAY_DIV);
        end
        else
        begin
            days_next = q2_reg;
            rem_fix   = rem;
        end
        sod_next = {rem_fix[9:0], lo2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= unix_seconds[31:7];
            lo1_reg  <= unix_seconds[6:0];
            prod_reg <= prod_next;
            x2_reg   <= x1_reg;
            lo2_reg  <= lo1_reg;
            q2_reg   <= prod_reg[50:35];
            qm2_reg  <= qm2_next;
            days_reg <= days_next;
            sod_reg  <= sod_next;
        end
    end

    assign days = days_reg;
    assign sod  = sod_reg;

endmodule

// ===== sv/ucal_clock.sv =====
// ----------------------------------------------------------------------------
// ucal_clock
// Seven-stage split of seconds of day into hour, minute and second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucal_clock (
    input  logic               clk,
    input  logic               en,
    input  logic [16:0]        sod,
    output ucal_pkg::hms_t     hms
);

    logic [16:0] s1_reg, s2_reg;
    logic [30:0] p1_reg, p1_next;
    logic [10:0] t2_reg, tme;
    logic [16:0] m2_reg, m2_next;

    logic [6:0]  sec_raw;
    logic [10:0] tm3_next, tm3_reg, tm4_reg, tm5_reg;
    logic [5:0]  sec3_next, sec3_reg, sec4_reg, sec5_reg, sec6_reg;

    logic [24:0] p4_reg, p4_next;
    logic [4:0]  he, he5_reg, he6_reg;
    logic [10:0] hm5_reg, hm5_next;
    logic [6:0]  mraw6_reg;

    ucal_pkg::hms_t hms_reg, hms_next;

    always_comb
    begin
        p1_next  = 31'(sod[16:2]) * 31'(ucal_pkg::MIN_RECIP);
        tme      = p1_reg[29:19];
        m2_next  = 17'(tme) * 17'(ucal_pkg::SIXTY);
        p4_next  = 25'(tm3_reg[10:2]) * 25'(ucal_pkg::MIN_RECIP);
        he       = p4_reg[23:19];
        hm5_next = 11'(he) * 11'(ucal_pkg::SIXTY);
    end

    // seconds correction: estimate of total minutes may be one low
    always_comb
    begin
        sec_raw = 7'(s2_reg - m2_reg);
        if (sec_raw >= 7'(ucal_pkg::SIXTY))
        begin
            tm3_next  = t2_reg + 11'd1;
            sec3_next = 6'(sec_raw - 7'(ucal_pkg::SIXTY));
        end
        else
        begin
            tm3_next  = t2_reg;
            sec3_next = sec_raw[5:0];
        end
    end

    // minutes correction: hour estimate may be one low
    always_comb
    begin
        hms_next.second = sec6_reg;
        if (mraw6_reg >= 7'(ucal_pkg::SIXTY))
        begin
            hms_next.hour   = he6_reg + 5'd1;
            hms_next.minute = 6'(mraw6_reg - 7'(ucal_pkg::SIXTY));
        end
        else
        begin
            hms_next.hour   = he6_reg;
            hms_next.minute = mraw6_reg[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= sod;
            p1_reg    <= p1_next;
            s2_reg    <= s1_reg;
            t2_reg    <= tme;
            m2_reg    <= m2_next;
            tm3_reg   <= tm3_next;
            sec3_reg  <= sec3_next;
            tm4_reg   <= tm3_reg;
            sec4_reg  <= sec3_reg;
            p4_reg    <= p4_next;
            tm5_reg   <= tm4_reg;
            sec5_reg  <= sec4_reg;
            he5_reg   <= he;
            hm5_reg   <= hm5_next;
            mraw6_reg <= 7'(tm5_reg - hm5_reg);
            he6_reg   <= he5_reg;
            sec6_reg  <= sec5_reg;
            hms_reg   <= hms_next;
        end
    end

    assign hms = hms_reg;

endmodule

// ===== sv/ucal_date.sv =====
// ----------------------------------------------------------------------------
// ucal_date
// Seven-stage conversion of days since 1970-01-01 into year, month, day.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucal_date (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        days,
    output ucal_pkg::ymd_t     ymd
);

    // D1: shift to 1600-03-01 and split the 400-year era
    logic [17:0] z;
    logic        era1_next, era1_reg, era2_reg, era3_reg, era4_reg, era5_reg;
    logic [17:0] doe1_next, doe1_reg;

    // D2: century
    logic [1:0]  cent2_next, cent2_reg, cent3_reg, cent4_reg, cent5_reg;
    logic [15:0] doe2_next, doe2_reg, doe3_reg, doe4_reg;

    // D3..D5: four-year cycle
    logic [31:0] pq3_reg, pq3_next;
    logic [4:0]  qe;
    logic [15:0] qm4_reg, qm4_next;
    logic [4:0]  qe4_reg;
    logic [11:0] r5;
    logic [4:0]  quad5_next, quad5_reg;
    logic [10:0] d5_next, d5_reg;

    // D6: year in cycle and day of year
    logic [1:0]  yr6;
    logic [8:0]  doy6_next, doy6_reg;
    logic [11:0] yb6_next, yb6_reg;

    // D7: month walk
    logic [3:0]  mi;
    ucal_pkg::ymd_t ymd_next, ymd_reg;

    always_comb
    begin
        z = 18'(days) + 18'(ucal_pkg::EPOCH_SHIFT);
        if (z >= 18'(ucal_pkg::DAYS_400Y))
        begin
            era1_next = 1'b1;
            doe1_next = z - 18'(ucal_pkg::DAYS_400Y);
        end
        else
        begin
            era1_next = 1'b0;
            doe1_next = z;
        end
    end

    // last day of an era lands in century 3 by construction
    always_comb
    begin
        cent2_next = 2'(doe1_reg >= 18'(ucal_pkg::DAYS_100Y))
                   + 2'(doe1_reg >= 18'(2 * ucal_pkg::DAYS_100Y))
                   + 2'(doe1_reg >= 18'(3 * ucal_pkg::DAYS_100Y));
        doe2_next  = 16'(doe1_reg - 18'(cent2_next) * 18'(ucal_pkg::DAYS_100Y));
    end

    always_comb
    begin
        pq3_next = 32'(doe2_reg) * 32'(ucal_pkg::QUAD_RECIP);
        qe       = pq3_reg[30:26];
        qm4_next = 16'(qe) * 16'(ucal_pkg::DAYS_4Y);
    end

    always_comb
    begin
        r5 = 12'(doe4_reg - qm4_reg);
        if (r5 >= 12'(ucal_pkg::DAYS_4Y))
        begin
            quad5_next = qe4_reg + 5'd1;
            d5_next    = 11'(r5 - 12'(ucal_pkg::DAYS_4Y));
        end
        else
        begin
            quad5_next = qe4_reg;
            d5_next    = r5[10:0];
        end
    end

    // leap day closing a four-year cycle stays in year 3
    always_comb
    begin
        yr6 = 2'(d5_reg >= 11'(ucal_pkg::DAYS_1Y))
            + 2'(d5_reg >= 11'(2 * ucal_pkg::DAYS_1Y))
            + 2'(d5_reg >= 11'(3 * ucal_pkg::DAYS_1Y));
        doy6_next = 9'(d5_reg - 11'(yr6) * 11'(ucal_pkg::DAYS_1Y));
        yb6_next  = 12'(ucal_pkg::BASE_YEAR)
                  + (era5_reg ? 12'd400 : 12'd0)
                  + 12'(cent5_reg) * 12'd100
                  + 12'({quad5_reg, 2'b00})
                  + 12'(yr6);
    end

    always_comb
    begin
        mi = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            mi = mi + 4'(doy6_reg >= ucal_pkg::month_start(4'(k)));
        end
        ymd_next.day = 5'(doy6_reg - ucal_pkg::month_start(mi) + 9'd1);
        if (mi >= ucal_pkg::JAN_IDX)
        begin
            ymd_next.month = mi - 4'd9;
            ymd_next.year  = yb6_reg + 12'd1;
        end
        else
        begin
            ymd_next.month = mi + 4'd3;
            ymd_next.year  = yb6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            era1_reg  <= era1_next;
            doe1_reg  <= doe1_next;
            era2_reg  <= era1_reg;
            cent2_reg <= cent2_next;
            doe2_reg  <= doe2_next;
            era3_reg  <= era2_reg;
            cent3_reg <= cent2_reg;
            doe3_reg  <= doe2_reg;
            pq3_reg   <= pq3_next;
            era4_reg  <= era3_reg;
            cent4_reg <= cent3_reg;
            doe4_reg  <= doe3_reg;
            qe4_reg   <= qe;
            qm4_reg   <= qm4_next;
            era5_reg  <= era4_reg;
            cent5_reg <= cent4_reg;
            quad5_reg <= quad5_next;
            d5_reg    <= d5_next;
            doy6_reg  <= doy6_next;
            yb6_reg   <= yb6_next;
            ymd_reg   <= ymd_next;
        end
    end

    assign ymd = ymd_reg;

endmodule

// ===== sv/unix_seconds_to_calendar_top.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_top
// Each accepted timestamp beat comes out, in order, as one calendar beat.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds when the output beat is not taken.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Structure:
//   ucal_day_split  3 stages  seconds -> days since 1970, seconds of day
//                             (reciprocal multiply by 1/675 on seconds/128,
//                             one compare-subtract correction)
//   ucal_clock      7 stages  seconds of day -> hour, minute, second
//   ucal_date       7 stages  days -> year, month, day via 400/100/4/1 year
//                             cycles from a 1600-03-01 base, March-first
//                             month walk, Jan/Feb moved to the next year
// Clock and date sections run side by side with equal depth, so their
// results line up with the valid bit at the last stage.

module unix_seconds_to_calendar_top (
    input  logic        clk,
    input  logic        rst_n,
    ucal_in_if.sink     stamp,
    ucal_out_if.source  civil
);

    localparam int NSTG = ucal_pkg::TOTAL_STAGES;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            en;

    logic [15:0]     days;
    logic [16:0]     sod;
    ucal_pkg::hms_t  hms;
    ucal_pkg::ymd_t  ymd;

    // Global advance: move when the last stage is empty or being taken.
    assign en          = !vld_reg[NSTG-1] || civil.ready;
    assign stamp.ready = en;

    always_comb
    begin
        vld_next = {vld_reg[NSTG-2:0], stamp.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    ucal_day_split u_day_split (
        .clk          (clk),
        .en           (en),
        .unix_seconds (stamp.unix_seconds),
        .days         (days),
        .sod          (sod)
    );

    ucal_clock u_clock (
        .clk (clk),
        .en  (en),
        .sod (sod),
        .hms (hms)
    );

    ucal_date u_date (
        .clk  (clk),
        .en   (en),
        .days (days),
        .ymd  (ymd)
    );

    // Output beat straight from the final stage registers
    assign civil.valid  = vld_reg[NSTG-1];
    assign civil.year   = ymd.year;
    assign civil.month  = ymd.month;
    assign civil.day    = ymd.day;
    assign civil.hour   = hms.hour;
    assign civil.minute = hms.minute;
    assign civil.second = hms.second;

endmodule

// ===== verif/tb_unix_seconds_to_calendar_top.sv =====
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_calendar_top
// Self-checking bench for the Unix seconds to calendar converter. Timestamp
// beats go in with bursty valid, and calendar beats come out under a
// back-pressure pattern that changes over time. Each result is checked in
// order against a behavioral date/time calculation done in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_unix_seconds_to_calendar_top;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_REPORTS  = 10;
    // pipeline is 10 deep; leave some margin after the last beat
    localparam int DRAIN_CYCLES = 24;

    // Civil arithmetic counts from 2000-03-01, the day after a 400-year leap day
    localparam longint MARCH_EPOCH_SECS = 64'sd951868800;
    localparam longint SECS_PER_DAY     = 64'sd86400;
    localparam longint ERA_DAYS         = 64'sd146097;
    localparam longint CENTURY_DAYS     = 64'sd36524;
    localparam longint QUAD_DAYS        = 64'sd1461;
    localparam longint YEAR_DAYS        = 64'sd365;
    localparam longint UNIX_MAX         = 64'sd4294967295;
    // Days from 0000-03-01 to 1970-01-01, for building test dates
    localparam longint CIVIL_TO_UNIX    = 64'sd719468;

    // Month lengths from March; index 0 is the rightmost element
    localparam logic [11:0][4:0] MARCH_MONTH_LEN = {
        5'd29, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } civil_t;

    // Receiver back-pressure styles
    typedef enum logic [1:0] {
        RX_STREAM,      // always ready
        RX_SPARSE,      // mostly ready
        RX_ALTERNATE,   // ready and not ready in turn
        RX_CHOKED       // mostly stalled
    } rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ucal_in_if  stamp ();
    ucal_out_if civil ();

    unix_seconds_to_calendar_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stamp (stamp),
        .civil (civil)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Timestamps waiting to be driven, and dates expected back, oldest first
    logic [31:0] stamp_queue [$];
    civil_t      expected_dates [$];
    int          mismatch_count = 0;

    // Sender burst state
    int burst_left;
    int gap_left;

    // Receiver pattern state
    rx_mode_t rx_mode;
    int       rx_mode_left;
    logic     rx_phase;

    // ------------------------------------------------------------------------
    // Date/time prediction. Signed 64-bit math throughout; SV division
    // truncates toward zero, so negative remainders are folded back by hand
    // to get floor semantics for instants before the March epoch.
    // ------------------------------------------------------------------------
    function automatic civil_t civil_from_unix(input logic [31:0] unix_secs);
        longint secs;
        longint days;
        longint sod;
        longint era;
        longint doe;
        longint cent;
        longint quad;
        longint yr;
        longint years;
        int     mon;
        civil_t res;

        secs = $signed({32'd0, unix_secs}) - MARCH_EPOCH_SECS;
        days = secs / SECS_PER_DAY;
        sod  = secs % SECS_PER_DAY;
        if (sod < 0)
        begin
            sod  += SECS_PER_DAY;
            days -= 1;
        end

        era = days / ERA_DAYS;
        doe = days % ERA_DAYS;
        if (doe < 0)
        begin
            doe += ERA_DAYS;
            era -= 1;
        end

        // last day of an era is the leap day of its 4th century
        cent = doe / CENTURY_DAYS;
        if (cent == 4)
            cent = 3;
        doe -= cent * CENTURY_DAYS;

        quad = doe / QUAD_DAYS;
        if (quad == 25)
            quad = 24;
        doe -= quad * QUAD_DAYS;

        // leap day closing a 4-year block stays in its 4th year
        yr = doe / YEAR_DAYS;
        if (yr == 4)
            yr = 3;
        doe -= yr * YEAR_DAYS;

        years = yr + 4 * quad + 100 * cent + 400 * era;

        mon = 0;
        while (mon < 11 && doe >= longint'(MARCH_MONTH_LEN[mon]))
        begin
            doe -= longint'(MARCH_MONTH_LEN[mon]);
            mon++;
        end
        // January and February belong to the next calendar year
        if (mon >= 10)
        begin
            mon   -= 12;
            years += 1;
        end

        res.year   = 12'(years + 2000);
        res.month  = 4'(mon + 3);
        res.day    = 5'(doe + 1);
        res.hour   = 5'(sod / 3600);
        res.minute = 6'((sod / 60) % 60);
        res.second = 6'(sod % 60);
        return res;
    endfunction

    // Day number (since 1970-01-01) of March 1st of a given year
    function automatic longint march_first_day(input int yr);
        longint yoe;
        longint doe;
        yoe = yr % 400;
        doe = 365 * yoe + yoe / 4 - yoe / 100;
        return longint'(yr / 400) * ERA_DAYS + doe - CIVIL_TO_UNIX;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: pulls timestamps from stamp_queue in bursts of random length
    // with random gaps. The expected date is recorded at the accepting edge.
    // Valid gets at most one NBA per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            stamp.valid        <= 1'b0;
            stamp.unix_seconds <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (stamp.valid && stamp.ready)
                expected_dates.push_back(civil_from_unix(stamp.unix_seconds));

            // only move on when the current beat is gone or none is offered
            if (!stamp.valid || stamp.ready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (stamp_queue.size() > 0)
                begin
                    next_valid = 1'b1;
                    stamp.unix_seconds <= stamp_queue.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // one in four bursts runs straight into the next
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                stamp.valid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a randomly chosen mode, redrawn whenever its random
    // run length is used up, so stalls land on every pipeline fill level, with
    // clean streaming stretches in between.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic next_ready;
        if (!rst_n)
        begin
            civil.ready <= 1'b0;
            rx_mode      = RX_STREAM;
            rx_mode_left = 0;
            rx_phase     = 1'b0;
        end
        else
        begin
            if (rx_mode_left <= 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 256);
            end
            rx_mode_left--;
            rx_phase = ~rx_phase;

            case (rx_mode)
                RX_STREAM:    next_ready = 1'b1;
                RX_SPARSE:    next_ready = ($urandom_range(0, 3) != 0);
                RX_ALTERNATE: next_ready = rx_phase;
                default:      next_ready = ($urandom_range(0, 3) == 0);
            endcase
            civil.ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted calendar beat is matched, in order, against the
    // oldest expected date. Only the first few failures are printed.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        civil_t got;
        civil_t want;
        if (rst_n && civil.valid && civil.ready)
        begin
            got = '{civil.year, civil.month, civil.day,
                    civil.hour, civil.minute, civil.second};
            if (expected_dates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected calendar beat: %0d-%0d-%0d %0d:%0d:%0d",
                             $realtime, got.year, got.month, got.day,
                             got.hour, got.minute, got.second);
            end
            else
            begin
                want = expected_dates.pop_front();
                if (got.year   !== want.year   || got.month  !== want.month  ||
                    got.day    !== want.day    || got.hour   !== want.hour   ||
                    got.minute !== want.minute || got.second !== want.second)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch: expected %0d-%0d-%0d %0d:%0d:%0d",
                                 $realtime,
                                 want.year, want.month, want.day,
                                 want.hour, want.minute, want.second);
                        $display("    got %0d-%0d-%0d %0d:%0d:%0d",
                                 got.year, got.month, got.day,
                                 got.hour, got.minute, got.second);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        longint t;
        longint sod;
        int     sel;

        stamp.valid        = 1'b0;
        stamp.unix_seconds = '0;
        civil.ready        = 1'b0;

        // Directed: field extremes, midnight and hour edges, leap-year rules at
        // 4-year, century and era level, the March epoch, the turn of a
        // year, the sign bit, and the top of the input range.
        stamp_queue = '{
            32'd0,          32'd3599,       32'd86399,      32'd86400,
            32'd68169600,   32'd68255999,   32'd68256000,
            32'd951782399,  32'd951782400,  32'd951868799,  32'd951868800,
            32'd1078012800, 32'd1078099199,
            32'd4107456000, 32'd4107542399, 32'd4107542400,
            32'd1609459199, 32'd1609459200,
            32'h7FFF_FFFF,  32'h8000_0000,  32'hFFFF_FFFE,  32'hFFFF_FFFF
        };

        // Random: half uniform over all 32 bits, the rest aimed at day
        // edges, late February / early March, New Year, and the range ends.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 9);
            case ($urandom_range(0, 3))
                0:       sod = 0;
                1:       sod = SECS_PER_DAY - 1;
                default: sod = longint'($urandom_range(0, 86399));
            endcase

            if (sel <= 4)
                t = longint'($urandom());
            else if (sel <= 6)
                t = longint'($urandom_range(0, 49709)) * SECS_PER_DAY
                    + longint'($urandom_range(0, 4)) - 2;
            else if (sel == 7)
                t = (march_first_day($urandom_range(1970, 2105))
                     - longint'($urandom_range(0, 2))) * SECS_PER_DAY + sod;
            else if (sel == 8)
                // Mar 1 + 305 is Dec 31, + 306 is Jan 1 of the next year
                t = (march_first_day($urandom_range(1970, 2105)) + 305
                     + longint'($urandom_range(0, 1))) * SECS_PER_DAY + sod;
            else if ($urandom_range(0, 1) == 0)
                t = longint'($urandom_range(0, 200));
            else
                t = UNIX_MAX - longint'($urandom_range(0, 200));

            if (t < 0)
                t = 0;
            if (t > UNIX_MAX)
                t = UNIX_MAX;
            stamp_queue.push_back(32'(t));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: everything sent, everything checked
        while (stamp_queue.size() != 0 || stamp.valid || expected_dates.size() != 0)
            @(negedge clk);

        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog; a normal run ends well before it fires
    initial
    begin
        #(2_000_000 * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ucal_pkg.sv
sv/ucal_in_if.sv
sv/ucal_out_if.sv
sv/ucal_day_split.sv
sv/ucal_clock.sv
sv/ucal_date.sv
sv/unix_seconds_to_calendar_top.sv
verif/tb_unix_seconds_to_calendar_top.sv
